### rtl/ilso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilso_pkg
// Constants and codes for the interval list set operation block.
// ----------------------------------------------------------------------------
package ilso_pkg;

	localparam int MAX_RANGES = 16;
	localparam int OUT_LIMIT  = 32;

	localparam int IDX_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W  = $clog2(MAX_RANGES + 1);
	localparam int EMIT_W = $clog2(OUT_LIMIT + 1);
	localparam int ADDR_W = 3;

	localparam logic signed [31:0] DOMAIN_MIN_RST = -32'sd2147483646;
	localparam logic signed [31:0] DOMAIN_MAX_RST = 32'sd2147483645;

	typedef enum logic [1:0] {
		KIND_LOAD_LEFT  = 2'd0,
		KIND_LOAD_RIGHT = 2'd1,
		KIND_RUN        = 2'd2,
		KIND_NONE       = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_UNION = 3'd0,
		OP_INTER = 3'd1,
		OP_DIFF  = 3'd2,
		OP_XOR   = 3'd3,
		OP_COMPL = 3'd4
	} op_t;

	// register index taken from paddr[2]
	localparam logic REG_DOMAIN_MIN = 1'b0;
	localparam logic REG_DOMAIN_MAX = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_SCAN_RD = 7'b0000010,
		ST_SCAN_S  = 7'b0000100,
		ST_SCAN_E  = 7'b0001000,
		ST_STEP    = 7'b0010000,
		ST_CLOSE   = 7'b0100000,
		ST_FINISH  = 7'b1000000
	} state_t;

	function automatic logic answer_bit(input logic [2:0] op, input logic l, input logic r);
		logic res;
		res = 1'b0;
		unique case (op)
			OP_UNION: res = l | r;
			OP_INTER: res = l & r;
			OP_DIFF:  res = l & ~r;
			OP_XOR:   res = l ^ r;
			OP_COMPL: res = ~l;
			default:  res = 1'b0;
		endcase
		return res;
	endfunction

endpackage

### rtl/interval_list_set_ops.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_list_set_ops
// Set operations on two loaded lists of inclusive ranges, swept boundary by
// boundary with one shared compare unit.
// ----------------------------------------------------------------------------
// A load item (left or right range) is taken while idle, and the block stays
// ready for further items. A run item sweeps the answer from domain_min
// upward: for each sweep point the sequencer reads every stored range once,
// first boundary then final, comparing each with the current point to get
// membership and the next boundary. With N ranges loaded in total at most
// 2*N+1 points lie below domain_max + 1. After the last point the run goes
// through ST_CLOSE to ST_FINISH (straight to ST_FINISH when the 32nd range
// closes or the domain is empty), stalling while out_valid waits on out_ready.
// in_ready is low for the whole run. One result item per answer range (at
// most 32), or one empty item; the run clears both lists and the overflow flag.
// ----------------------------------------------------------------------------
module interval_list_set_ops
	import ilso_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// input items
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               kind,
	input  logic signed [31:0]       range_first,
	input  logic signed [31:0]       range_final,
	input  logic [2:0]               operation,
	// result items
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [31:0]       out_first,
	output logic signed [31:0]       out_final,
	output logic                     is_empty,
	output logic                     last,
	output logic                     overflowed,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	state_t state_q;

	logic signed [31:0] dmin_q, dmax_q;
	logic signed [31:0] left_first_q  [MAX_RANGES];
	logic signed [31:0] left_final_q  [MAX_RANGES];
	logic signed [31:0] right_first_q [MAX_RANGES];
	logic signed [31:0] right_final_q [MAX_RANGES];
	logic [CNT_W-1:0]   left_cnt_q, right_cnt_q;
	logic               overflow_q;

	logic [2:0]         op_q;
	logic signed [32:0] p_q, best_q;
	logic signed [31:0] rd_first_q, rd_final_q;
	logic               side_q;
	logic [IDX_W-1:0]   idx_q;
	logic               s_le_q, l_q, r_q;
	logic               open_q;
	logic signed [31:0] start_q;
	logic               pend_v_q;
	logic signed [31:0] pend_first_q, pend_final_q;
	logic [EMIT_W-1:0]  emit_cnt_q;

	logic               out_valid_q;
	logic signed [31:0] out_first_q, out_final_q;
	logic               is_empty_q, last_q, overflowed_q;

	// combinational
	logic               in_acc, cfg_we;
	logic signed [32:0] dmax_p1, cmp_v;
	logic               cmp_gt, cmp_lt;
	logic [CNT_W-1:0]   idx_nx, side_cnt;
	logic               on_w, in_step, in_close, in_fin;
	logic               close_req, is_32nd, need_out, stall, out_we;
	logic signed [31:0] close_final;

	assign pready   = 1'b1;
	assign cfg_we   = psel & penable & pwrite & pready;
	assign prdata   = (paddr[2] == REG_DOMAIN_MAX) ? dmax_q : dmin_q;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;

	assign out_valid  = out_valid_q;
	assign out_first  = out_first_q;
	assign out_final  = out_final_q;
	assign is_empty   = is_empty_q;
	assign last       = last_q;
	assign overflowed = overflowed_q;

	assign dmax_p1 = {dmax_q[31], dmax_q} + 33'sd1;

	// shared compare unit: one boundary against the point and the best so far
	always_comb begin
		if (state_q == ST_SCAN_E) begin
			cmp_v = {rd_final_q[31], rd_final_q} + 33'sd1;
		end else begin
			cmp_v = {rd_first_q[31], rd_first_q};
		end
		cmp_gt = cmp_v > p_q;
		cmp_lt = cmp_v < best_q;
	end

	assign idx_nx   = CNT_W'(idx_q) + CNT_W'(1);
	assign side_cnt = side_q ? right_cnt_q : left_cnt_q;

	always_comb begin
		in_step     = (state_q == ST_STEP);
		in_close    = (state_q == ST_CLOSE);
		in_fin      = (state_q == ST_FINISH);
		on_w        = answer_bit(op_q, l_q, r_q);
		close_req   = open_q & ((in_step & ~on_w) | in_close);
		close_final = in_step ? 32'(p_q - 33'sd1) : dmax_q;
		is_32nd     = (emit_cnt_q == EMIT_W'(OUT_LIMIT - 1));
		// a closed range pushes the pending one out; the run end flushes it
		need_out    = (close_req & pend_v_q) | in_fin;
		stall       = need_out & out_valid_q & ~out_ready;
		out_we      = need_out & ~stall;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmin_q <= DOMAIN_MIN_RST;
			dmax_q <= DOMAIN_MAX_RST;
		end else if (cfg_we) begin
			if (paddr[2] == REG_DOMAIN_MAX) begin
				dmax_q <= pwdata;
			end else begin
				dmin_q <= pwdata;
			end
		end
	end

	// range storage
	always_ff @(posedge clk) begin
		if (in_acc && kind == KIND_LOAD_LEFT && left_cnt_q < CNT_W'(MAX_RANGES)) begin
			left_first_q[left_cnt_q[IDX_W-1:0]] <= range_first;
			left_final_q[left_cnt_q[IDX_W-1:0]] <= range_final;
		end
		if (in_acc && kind == KIND_LOAD_RIGHT && right_cnt_q < CNT_W'(MAX_RANGES)) begin
			right_first_q[right_cnt_q[IDX_W-1:0]] <= range_first;
			right_final_q[right_cnt_q[IDX_W-1:0]] <= range_final;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_we) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_we) begin
			out_first_q  <= pend_v_q ? pend_first_q : '0;
			out_final_q  <= pend_v_q ? pend_final_q : '0;
			is_empty_q   <= ~pend_v_q;
			last_q       <= in_fin;
			overflowed_q <= overflow_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			left_cnt_q  <= '0;
			right_cnt_q <= '0;
			overflow_q  <= 1'b0;
			open_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			emit_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (kind)
							KIND_LOAD_LEFT: begin
								if (left_cnt_q < CNT_W'(MAX_RANGES)) begin
									left_cnt_q <= left_cnt_q + CNT_W'(1);
								end else begin
									overflow_q <= 1'b1;
								end
							end
							KIND_LOAD_RIGHT: begin
								if (right_cnt_q < CNT_W'(MAX_RANGES)) begin
									right_cnt_q <= right_cnt_q + CNT_W'(1);
								end else begin
									overflow_q <= 1'b1;
								end
							end
							KIND_RUN: begin
								op_q       <= operation;
								open_q     <= 1'b0;
								pend_v_q   <= 1'b0;
								emit_cnt_q <= '0;
								p_q        <= {dmin_q[31], dmin_q};
								state_q    <= (dmin_q > dmax_q) ? ST_FINISH : ST_SCAN_RD;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN_RD: begin
					best_q <= dmax_p1;
					l_q    <= 1'b0;
					r_q    <= 1'b0;
					idx_q  <= '0;
					if (left_cnt_q != '0) begin
						side_q     <= 1'b0;
						rd_first_q <= left_first_q[0];
						rd_final_q <= left_final_q[0];
						state_q    <= ST_SCAN_S;
					end else if (right_cnt_q != '0) begin
						side_q     <= 1'b1;
						rd_first_q <= right_first_q[0];
						rd_final_q <= right_final_q[0];
						state_q    <= ST_SCAN_S;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_SCAN_S: begin
					s_le_q <= ~cmp_gt;
					if (cmp_gt && cmp_lt) begin
						best_q <= cmp_v;
					end
					state_q <= ST_SCAN_E;
				end
				ST_SCAN_E: begin
					if (cmp_gt && cmp_lt) begin
						best_q <= cmp_v;
					end
					// point lies in [first, final] when first <= p < final + 1
					if (s_le_q && cmp_gt) begin
						if (side_q) begin
							r_q <= 1'b1;
						end else begin
							l_q <= 1'b1;
						end
					end
					if (idx_nx != side_cnt) begin
						idx_q   <= idx_nx[IDX_W-1:0];
						state_q <= ST_SCAN_S;
						if (side_q) begin
							rd_first_q <= right_first_q[idx_nx[IDX_W-1:0]];
							rd_final_q <= right_final_q[idx_nx[IDX_W-1:0]];
						end else begin
							rd_first_q <= left_first_q[idx_nx[IDX_W-1:0]];
							rd_final_q <= left_final_q[idx_nx[IDX_W-1:0]];
						end
					end else if (!side_q && right_cnt_q != '0) begin
						side_q     <= 1'b1;
						idx_q      <= '0;
						rd_first_q <= right_first_q[0];
						rd_final_q <= right_final_q[0];
						state_q    <= ST_SCAN_S;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (!stall) begin
						if (on_w && !open_q) begin
							start_q <= p_q[31:0];
							open_q  <= 1'b1;
						end
						if (close_req) begin
							open_q       <= 1'b0;
							pend_v_q     <= 1'b1;
							pend_first_q <= start_q;
							pend_final_q <= close_final;
							emit_cnt_q   <= emit_cnt_q + EMIT_W'(1);
						end
						p_q <= best_q;
						if (close_req && is_32nd) begin
							state_q <= ST_FINISH;
						end else if (best_q == dmax_p1) begin
							state_q <= ST_CLOSE;
						end else begin
							state_q <= ST_SCAN_RD;
						end
					end
				end
				ST_CLOSE: begin
					if (!stall) begin
						if (close_req) begin
							open_q       <= 1'b0;
							pend_v_q     <= 1'b1;
							pend_first_q <= start_q;
							pend_final_q <= close_final;
							emit_cnt_q   <= emit_cnt_q + EMIT_W'(1);
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!stall) begin
						left_cnt_q  <= '0;
						right_cnt_q <= '0;
						overflow_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		left_cnt_q <= CNT_W'(MAX_RANGES) && right_cnt_q <= CNT_W'(MAX_RANGES))
		else $error("list count beyond capacity");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && kind == KIND_RUN) |=> !in_ready)
		else $error("ready still high after run item");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_we && in_fin) |=>
		(state_q == ST_IDLE && left_cnt_q == '0 && right_cnt_q == '0 && !overflow_q))
		else $error("run did not clear lists with its last item");

	a_best_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_S || state_q == ST_SCAN_E) |-> (best_q > p_q))
		else $error("next boundary not above sweep point");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emit_cnt_q <= EMIT_W'(OUT_LIMIT))
		else $error("too many result ranges");

endmodule
